>>> rtl/rama_pkg.sv
`default_nettype none
package rama_pkg;

  // Item kinds
  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_QUERY  = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Result status codes
  localparam logic [1:0] STATUS_ADD    = 2'd0;
  localparam logic [1:0] STATUS_QUERY  = 2'd1;
  localparam logic [1:0] STATUS_CLEAR  = 2'd2;
  localparam logic [1:0] STATUS_REJECT = 2'd3;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_NODE_RD,
    S_NODE_CHK,
    S_PUSH_L,
    S_PUSH_R,
    S_PUSH_N,
    S_DECIDE,
    S_RET,
    S_RESUME,
    S_CMB_L,
    S_CMB_R,
    S_OUT
  } state_t;

  // What a parked frame does when its child returns
  typedef enum logic [1:0] {
    PH_SPLIT_LEFT,
    PH_ONE,
    PH_BOTH
  } phase_t;

endpackage
`default_nettype wire

>>> rtl/rama_node_ram.sv
`default_nettype none
// Node store: one write port, one registered read port.
module rama_node_ram #(
  parameter int AW = 11,
  parameter int DW = 64
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> rtl/range_add_range_max_tree.sv
`default_nettype none
// Range-add / range-maximum store over 2^LEVELS positions, a lazy segment
// tree held in one node memory (best total and pending amount per node).
// One item is in work at a time; in_stall is high until its word has been
// moved into the output register. An add or query walks the tree with a
// small frame stack; each node visit reads, checks and decides on the node
// (S_NODE_RD, S_NODE_CHK, S_DECIDE), with S_PUSH_L, S_PUSH_R and S_PUSH_N
// added when a pending amount is pushed to the children. Each return to
// the parent frame passes S_RET and S_RESUME, and on an add S_CMB_L and
// S_CMB_R for the re-read and merge of both children. A wide range visits
// up to roughly 4*LEVELS nodes. The pace of the walk is set by the single
// read port of the node memory, which every read-modify-write of a node
// passes through, and by the one shared adder. A clear item sweeps the
// memory, one node per cycle, over all 2^(LEVELS+1) node words (2048 at
// LEVELS = 10). The same sweep runs after reset, during which no item is
// taken. Sums wrap to VALUE_WIDTH bits and set the sticky overflow flag,
// which only reset clears.
module range_add_range_max_tree #(
  parameter int LEVELS      = 10,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         kind,
  input  wire logic [9:0]         left_index,
  input  wire logic [9:0]         right_index,
  input  wire logic signed [15:0] add_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      max_value,
  output logic [1:0]              status,
  output logic                    overflow
);

  localparam int IW  = LEVELS;
  localparam int NW  = LEVELS + 1;
  localparam int DPW = $clog2(LEVELS + 1);
  localparam int VW  = VALUE_WIDTH;
  localparam int XW  = ((VW > 16) ? VW : 16) + 1;
  localparam int EXT = (VW > 32) ? VW : 32;

  rama_pkg::state_t state, state_next;

  // Current frame
  logic [NW-1:0]        cur_node;
  logic [DPW-1:0]       cur_depth;
  logic [IW-1:0]        cur_start;
  logic [IW-1:0]        cur_lo;
  logic [IW-1:0]        cur_hi;
  rama_pkg::phase_t     cur_phase;
  logic signed [VW-1:0] acc;

  // Parked frames, indexed by depth
  logic [NW-1:0]        stk_node  [LEVELS+1];
  logic [IW-1:0]        stk_start [LEVELS+1];
  logic [IW-1:0]        stk_lo    [LEVELS+1];
  logic [IW-1:0]        stk_hi    [LEVELS+1];
  rama_pkg::phase_t     stk_phase [LEVELS+1];
  logic signed [VW-1:0] stk_acc   [LEVELS+1];

  // Item and working registers
  logic [1:0]           op_kind;
  logic [1:0]           op_status;
  logic signed [15:0]   op_value;
  logic signed [VW-1:0] nb;
  logic signed [VW-1:0] np;
  logic signed [VW-1:0] ret;
  logic                 ovf_flag;
  logic [NW-1:0]        clr_cnt;
  logic                 clr_item;

  // Node memory
  logic                 wr_en;
  logic [NW-1:0]        wr_addr;
  logic [2*VW-1:0]      wr_data;
  logic [NW-1:0]        rd_addr;
  logic [2*VW-1:0]      rd_data;
  logic signed [VW-1:0] rd_best;
  logic signed [VW-1:0] rd_pend;

  assign rd_best = rd_data[2*VW-1:VW];
  assign rd_pend = rd_data[VW-1:0];

  rama_node_ram #(
    .AW(NW),
    .DW(2*VW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Shared adder with wrap detection
  logic signed [XW-1:0] add_a, add_b, add_sum;
  logic signed [VW-1:0] sum_w;
  logic                 add_en, add_ovf;

  assign add_sum = add_a + add_b;
  assign sum_w   = add_sum[VW-1:0];
  assign add_ovf = add_en && (XW'(sum_w) != add_sum);

  // Merge of two child totals
  logic signed [VW-1:0] cmb_max;
  assign cmb_max = (acc >= sum_w) ? acc : sum_w;

  // Node geometry
  logic [IW-1:0] span_mask, half, mid;
  logic [NW-1:0] child_l, child_r;
  logic          full_cover, at_leaf, go_left, go_right;

  assign span_mask  = {IW{1'b1}} >> cur_depth;
  assign half       = span_mask & ~(span_mask >> 1);
  assign mid        = cur_start | half;
  assign full_cover = (cur_lo == cur_start) && (cur_hi == (cur_start | span_mask));
  assign at_leaf    = (cur_depth == DPW'(LEVELS));
  assign child_l    = {cur_node[NW-2:0], 1'b0};
  assign child_r    = {cur_node[NW-2:0], 1'b1};
  assign go_left    = (cur_lo < mid);
  assign go_right   = (cur_hi >= mid);

  // Input checks
  logic in_accept, bad_range;
  assign in_accept = in_valid && !in_stall;
  assign bad_range = (kind == rama_pkg::KIND_UNUSED) || (left_index > right_index) ||
                     ((right_index >> LEVELS) != 10'd0);
  assign in_stall  = (state != rama_pkg::S_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      rama_pkg::S_IDLE: begin
        if (in_accept) begin
          if (kind == rama_pkg::KIND_CLEAR) state_next = rama_pkg::S_CLEAR;
          else if (bad_range)               state_next = rama_pkg::S_OUT;
          else                              state_next = rama_pkg::S_NODE_RD;
        end
      end
      rama_pkg::S_CLEAR: begin
        if (&clr_cnt) state_next = clr_item ? rama_pkg::S_OUT : rama_pkg::S_IDLE;
      end
      rama_pkg::S_NODE_RD:  state_next = rama_pkg::S_NODE_CHK;
      rama_pkg::S_NODE_CHK: begin
        if (!at_leaf && (rd_pend != '0)) state_next = rama_pkg::S_PUSH_L;
        else                             state_next = rama_pkg::S_DECIDE;
      end
      rama_pkg::S_PUSH_L: state_next = rama_pkg::S_PUSH_R;
      rama_pkg::S_PUSH_R: state_next = rama_pkg::S_PUSH_N;
      rama_pkg::S_PUSH_N: state_next = rama_pkg::S_DECIDE;
      rama_pkg::S_DECIDE: begin
        state_next = full_cover ? rama_pkg::S_RET : rama_pkg::S_NODE_RD;
      end
      rama_pkg::S_RET: begin
        state_next = (cur_depth == '0) ? rama_pkg::S_OUT : rama_pkg::S_RESUME;
      end
      rama_pkg::S_RESUME: begin
        if (cur_phase == rama_pkg::PH_SPLIT_LEFT)  state_next = rama_pkg::S_NODE_RD;
        else if (op_kind == rama_pkg::KIND_ADD)    state_next = rama_pkg::S_CMB_L;
        else                                       state_next = rama_pkg::S_RET;
      end
      rama_pkg::S_CMB_L: state_next = rama_pkg::S_CMB_R;
      rama_pkg::S_CMB_R: state_next = rama_pkg::S_RET;
      rama_pkg::S_OUT: begin
        if (!out_valid || !out_stall) state_next = rama_pkg::S_IDLE;
      end
      default: state_next = rama_pkg::S_IDLE;
    endcase
  end

  // Memory and adder control
  always_comb begin
    rd_addr = cur_node;
    wr_en   = 1'b0;
    wr_addr = cur_node;
    wr_data = '0;
    add_a   = XW'(nb);
    add_b   = XW'(np);
    add_en  = 1'b0;
    case (state)
      rama_pkg::S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt;
      end
      rama_pkg::S_NODE_CHK: rd_addr = child_l;
      rama_pkg::S_PUSH_L: begin
        rd_addr = child_r;
        add_a   = XW'(rd_pend);
        add_en  = 1'b1;
        wr_en   = 1'b1;
        wr_addr = child_l;
        wr_data = {rd_best, sum_w};
      end
      rama_pkg::S_PUSH_R: begin
        add_a   = XW'(rd_pend);
        add_en  = 1'b1;
        wr_en   = 1'b1;
        wr_addr = child_r;
        wr_data = {rd_best, sum_w};
      end
      rama_pkg::S_PUSH_N: begin
        add_en  = 1'b1;
        wr_en   = 1'b1;
        wr_data = {sum_w, {VW{1'b0}}};
      end
      rama_pkg::S_DECIDE: begin
        if (full_cover) begin
          add_en = 1'b1;
          if (op_kind == rama_pkg::KIND_ADD) begin
            add_a   = XW'(np);
            add_b   = XW'(op_value);
            wr_en   = 1'b1;
            wr_data = {nb, sum_w};
          end
        end
      end
      rama_pkg::S_RESUME: rd_addr = child_l;
      rama_pkg::S_CMB_L: begin
        rd_addr = child_r;
        add_a   = XW'(rd_best);
        add_b   = XW'(rd_pend);
        add_en  = 1'b1;
      end
      rama_pkg::S_CMB_R: begin
        add_a   = XW'(rd_best);
        add_b   = XW'(rd_pend);
        add_en  = 1'b1;
        wr_en   = 1'b1;
        wr_data = {cmb_max, {VW{1'b0}}};
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= rama_pkg::S_CLEAR;
      clr_cnt  <= '0;
      clr_item <= 1'b0;
      ovf_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (add_ovf) ovf_flag <= 1'b1;
      if (state == rama_pkg::S_CLEAR) clr_cnt <= clr_cnt + NW'(1);
      if (in_accept) begin
        clr_item <= (kind == rama_pkg::KIND_CLEAR);
        clr_cnt  <= '0;
      end
    end
  end

  // Frame walk and working values
  always_ff @(posedge clk) begin
    case (state)
      rama_pkg::S_IDLE: begin
        if (in_accept) begin
          op_kind   <= kind;
          op_value  <= add_value;
          ret       <= '0;
          cur_node  <= NW'(1);
          cur_depth <= '0;
          cur_start <= '0;
          cur_lo    <= IW'(left_index);
          cur_hi    <= IW'(right_index);
          if (kind == rama_pkg::KIND_CLEAR) op_status <= rama_pkg::STATUS_CLEAR;
          else if (bad_range)               op_status <= rama_pkg::STATUS_REJECT;
          else if (kind == rama_pkg::KIND_ADD) op_status <= rama_pkg::STATUS_ADD;
          else                              op_status <= rama_pkg::STATUS_QUERY;
        end
      end
      rama_pkg::S_NODE_CHK: begin
        nb <= rd_best;
        np <= rd_pend;
      end
      rama_pkg::S_PUSH_N: begin
        nb <= sum_w;
        np <= '0;
      end
      rama_pkg::S_DECIDE: begin
        if (full_cover) begin
          if (op_kind != rama_pkg::KIND_ADD) ret <= sum_w;
        end else begin
          // park this frame, step into the first child on the range
          stk_node[cur_depth]  <= cur_node;
          stk_start[cur_depth] <= cur_start;
          stk_lo[cur_depth]    <= cur_lo;
          stk_hi[cur_depth]    <= cur_hi;
          stk_acc[cur_depth]   <= acc;
          stk_phase[cur_depth] <= (go_left && go_right) ? rama_pkg::PH_SPLIT_LEFT
                                                        : rama_pkg::PH_ONE;
          cur_depth <= cur_depth + DPW'(1);
          if (go_left) begin
            cur_node <= child_l;
            if (go_right) cur_hi <= mid - IW'(1);
          end else begin
            cur_node  <= child_r;
            cur_start <= mid;
          end
        end
      end
      rama_pkg::S_RET: begin
        if (cur_depth != '0) begin
          cur_node  <= stk_node[cur_depth - DPW'(1)];
          cur_start <= stk_start[cur_depth - DPW'(1)];
          cur_lo    <= stk_lo[cur_depth - DPW'(1)];
          cur_hi    <= stk_hi[cur_depth - DPW'(1)];
          cur_phase <= stk_phase[cur_depth - DPW'(1)];
          acc       <= stk_acc[cur_depth - DPW'(1)];
          cur_depth <= cur_depth - DPW'(1);
        end
      end
      rama_pkg::S_RESUME: begin
        if (cur_phase == rama_pkg::PH_SPLIT_LEFT) begin
          // left half done: keep its result, go right
          stk_node[cur_depth]  <= cur_node;
          stk_start[cur_depth] <= cur_start;
          stk_lo[cur_depth]    <= cur_lo;
          stk_hi[cur_depth]    <= cur_hi;
          stk_acc[cur_depth]   <= ret;
          stk_phase[cur_depth] <= rama_pkg::PH_BOTH;
          cur_depth <= cur_depth + DPW'(1);
          cur_node  <= child_r;
          cur_start <= mid;
          cur_lo    <= mid;
        end else if (op_kind != rama_pkg::KIND_ADD &&
                     cur_phase == rama_pkg::PH_BOTH) begin
          if (acc >= ret) ret <= acc;
        end
      end
      rama_pkg::S_CMB_L: acc <= sum_w;
      default: begin
      end
    endcase
  end

  // Output register
  logic signed [EXT-1:0] ret_ext;
  assign ret_ext = EXT'(ret);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      overflow  <= 1'b0;
    end else if (state == rama_pkg::S_OUT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
      overflow  <= ovf_flag;
      max_value <= ret_ext[31:0];
      status    <= op_status;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/rama_checker.sv
`default_nettype none
// Port-level checks for the range-add / range-maximum store.
module rama_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] max_value,
  input wire logic [1:0]         status,
  input wire logic               overflow
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(max_value) && $stable(status))
    else $error("stalled result word changed");

  // one item at a time: busy straight after an accept
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  // clearing pass after reset
  a_reset_sweep: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("input open during clearing pass");

  // sticky overflow
  a_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow |=> overflow)
    else $error("overflow flag dropped");

  // only a query gives a non-zero maximum
  a_zero_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != rama_pkg::STATUS_QUERY |-> max_value == 32'sd0)
    else $error("non-query word carries a maximum");

endmodule

bind range_add_range_max_tree rama_checker u_rama_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .max_value (max_value),
  .status    (status),
  .overflow  (overflow)
);
`default_nettype wire

>>> tb/tb_range_add_range_max_tree.sv
`timescale 1ns / 1ps
module tb_range_add_range_max_tree;

  localparam int LEVELS = 10;
  localparam int VALUE_WIDTH = 32;
  localparam int LEAVES = 1 << LEVELS;
  localparam int NODES = 2 << LEVELS;

  typedef struct packed {
    logic signed [31:0] max_value;
    logic [1:0]         status;
    logic               overflow;
  } result_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         kind;
  logic [9:0]         left_index;
  logic [9:0]         right_index;
  logic signed [15:0] add_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] max_value;
  logic [1:0]         status;
  logic               overflow;

  // Predicted tree: values held sign-extended to 64 bits
  logic signed [63:0] tree_best [NODES];
  logic signed [63:0] tree_pend [NODES];
  bit                 tree_mark [NODES];
  bit                 sticky_ovf;

  result_t pending_results[$];
  int      fail_count;
  bit      idle_enable;
  int      out_hold;

  range_add_range_max_tree #(.LEVELS(LEVELS), .VALUE_WIDTH(VALUE_WIDTH)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .left_index(left_index), .right_index(right_index),
    .add_value(add_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .max_value(max_value), .status(status), .overflow(overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Wrapping add at the value width, raising the sticky flag on overflow
  function automatic logic signed [63:0] sum_wrap(logic signed [63:0] a,
                                                  logic signed [63:0] b);
    logic signed [63:0] s;
    logic signed [63:0] w;
    s = a + b;
    w = {{32{s[31]}}, s[31:0]};
    if (w != s || (a[63] == b[63] && s[63] != a[63]))
      sticky_ovf = 1'b1;
    return w;
  endfunction

  function automatic logic signed [63:0] larger(logic signed [63:0] a,
                                                logic signed [63:0] b);
    return (a >= b) ? a : b;
  endfunction

  function automatic void clear_tree();
    for (int n = 0; n < NODES; n++) begin
      tree_best[n] = '0;
      tree_pend[n] = '0;
      tree_mark[n] = 1'b0;
    end
  endfunction

  // Pass a node's pending amount to its two children (never at leaves)
  function automatic void push_pending(int node, int depth);
    logic signed [63:0] p;
    if (depth >= LEVELS || !tree_mark[node])
      return;
    p = tree_pend[node];
    tree_mark[node] = 1'b0;
    tree_mark[2*node] = 1'b1;
    tree_mark[2*node+1] = 1'b1;
    tree_pend[2*node] = sum_wrap(tree_pend[2*node], p);
    tree_pend[2*node+1] = sum_wrap(tree_pend[2*node+1], p);
    tree_best[node] = sum_wrap(tree_best[node], p);
    tree_pend[node] = '0;
  endfunction

  function automatic logic signed [63:0] node_total(int node);
    return sum_wrap(tree_best[node], tree_pend[node]);
  endfunction

  function automatic void add_range(logic signed [63:0] v, int depth, int node,
                                    int lo, int hi);
    int span;
    int start;
    int mid;
    span = 1 << (LEVELS - depth);
    start = (node - (1 << depth)) * span;
    mid = start + span / 2;
    push_pending(node, depth);
    if (hi - lo + 1 == span && lo == start) begin
      tree_mark[node] = 1'b1;
      tree_pend[node] = sum_wrap(tree_pend[node], v);
      return;
    end
    if (hi < mid) begin
      add_range(v, depth + 1, 2*node, lo, hi);
    end else if (lo >= mid) begin
      add_range(v, depth + 1, 2*node+1, lo, hi);
    end else begin
      add_range(v, depth + 1, 2*node, lo, mid - 1);
      add_range(v, depth + 1, 2*node+1, mid, hi);
    end
    tree_best[node] = larger(node_total(2*node), node_total(2*node+1));
  endfunction

  function automatic logic signed [63:0] max_over(int depth, int node, int lo, int hi);
    int span;
    int start;
    int mid;
    logic signed [63:0] a;
    logic signed [63:0] b;
    span = 1 << (LEVELS - depth);
    start = (node - (1 << depth)) * span;
    mid = start + span / 2;
    push_pending(node, depth);
    if (hi - lo + 1 == span && lo == start)
      return node_total(node);
    if (hi < mid)
      return max_over(depth + 1, 2*node, lo, hi);
    if (lo >= mid)
      return max_over(depth + 1, 2*node+1, lo, hi);
    a = max_over(depth + 1, 2*node, lo, mid - 1);
    b = max_over(depth + 1, 2*node+1, mid, hi);
    return larger(a, b);
  endfunction

  // Expected result word for one accepted item
  function automatic result_t predict_word(logic [1:0] k, int lo, int hi,
                                           logic signed [15:0] v);
    result_t r;
    logic signed [63:0] m;
    r = '0;
    if (k == rama_pkg::KIND_CLEAR) begin
      clear_tree();
      r.status = rama_pkg::STATUS_CLEAR;
    end else if (k == rama_pkg::KIND_UNUSED || lo > hi || hi >= LEAVES) begin
      r.status = rama_pkg::STATUS_REJECT;
    end else if (k == rama_pkg::KIND_ADD) begin
      add_range(64'(v), 0, 1, lo, hi);
      r.status = rama_pkg::STATUS_ADD;
    end else begin
      m = max_over(0, 1, lo, hi);
      r.max_value = m[31:0];
      r.status = rama_pkg::STATUS_QUERY;
    end
    r.overflow = sticky_ovf;
    return r;
  endfunction

  // Send one word, with an optional random gap before it
  task automatic send_word(logic [1:0] k, logic [9:0] lo, logic [9:0] hi,
                           logic signed [15:0] v);
    int gap;
    result_t exp_word;
    gap = 0;
    if (idle_enable && $urandom_range(0, 3) == 0)
      gap = $urandom_range(1, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    left_index <= lo;
    right_index <= hi;
    add_value <= v;
    do @(posedge clk); while (!(in_valid && !in_stall));
    exp_word = predict_word(k, lo, hi, v);
    pending_results.insert(pending_results.size(), exp_word);
  endtask

  // Random output stall in bursts
  always @(posedge clk) begin
    if (idle_enable && out_hold == 0 && $urandom_range(0, 5) == 0) begin
      out_hold <= $urandom_range(1, 11);
      out_stall <= 1'b1;
    end else if (out_hold > 1) begin
      out_hold <= out_hold - 1;
    end else begin
      out_hold <= 0;
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    result_t exp_w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word max=%0d status=%0d ovf=%0d",
                 $time, max_value, status, overflow);
        fail_count++;
      end else begin
        exp_w = pending_results.pop_front();
        if (max_value !== exp_w.max_value) begin
          $display("%0t: max_value expected %0d actual %0d", $time,
                   exp_w.max_value, max_value);
          fail_count++;
        end
        if (status !== exp_w.status) begin
          $display("%0t: status expected %0d actual %0d", $time,
                   exp_w.status, status);
          fail_count++;
        end
        if (overflow !== exp_w.overflow) begin
          $display("%0t: overflow expected %0d actual %0d", $time,
                   exp_w.overflow, overflow);
          fail_count++;
        end
      end
    end
  end

  task automatic test_extremes();
    send_word(rama_pkg::KIND_QUERY, 10'd0, 10'd1023, 16'sd0);
    send_word(rama_pkg::KIND_ADD, 10'd0, 10'd1023, 16'sd32767);
    send_word(rama_pkg::KIND_ADD, 10'd0, 10'd0, 16'sh8000);
    send_word(rama_pkg::KIND_QUERY, 10'd0, 10'd0, 16'sd0);
    send_word(rama_pkg::KIND_ADD, 10'd1023, 10'd1023, 16'sd32767);
    send_word(rama_pkg::KIND_QUERY, 10'd1023, 10'd1023, 16'sd0);
    send_word(rama_pkg::KIND_ADD, 10'd341, 10'd682, -16'sd1);
    send_word(rama_pkg::KIND_QUERY, 10'd340, 10'd683, 16'sd0);
    send_word(rama_pkg::KIND_QUERY, 10'd0, 10'd1023, -16'sd1);
    send_word(rama_pkg::KIND_ADD, 10'd512, 10'd511, 16'sd5);
    send_word(rama_pkg::KIND_QUERY, 10'd1023, 10'd0, 16'sd0);
    send_word(rama_pkg::KIND_UNUSED, 10'd3, 10'd9, 16'sd7);
    send_word(rama_pkg::KIND_CLEAR, 10'd0, 10'd0, 16'sd0);
    send_word(rama_pkg::KIND_QUERY, 10'd0, 10'd1023, 16'sd0);
    send_word(rama_pkg::KIND_ADD, 10'd511, 10'd512, 16'sd100);
    send_word(rama_pkg::KIND_QUERY, 10'd512, 10'd512, 16'sd0);
  endtask

  // Mostly adds and queries over random ranges, with some clears and rejects
  task automatic test_random(int count);
    int lo;
    int hi;
    int pick;
    logic [1:0] k;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      lo = $urandom_range(0, LEAVES - 1);
      case ($urandom_range(0, 3))
        0: hi = lo;
        1: hi = lo + $urandom_range(0, 15);
        2: hi = $urandom_range(lo, LEAVES - 1);
        default: begin
          lo = 0;
          hi = LEAVES - 1 - $urandom_range(0, 3);
        end
      endcase
      if (hi > LEAVES - 1)
        hi = LEAVES - 1;
      if (pick < 46) k = rama_pkg::KIND_ADD;
      else if (pick < 92) k = rama_pkg::KIND_QUERY;
      else if (pick < 94) k = rama_pkg::KIND_CLEAR;
      else if (pick < 96) k = rama_pkg::KIND_UNUSED;
      else begin
        k = logic'($urandom_range(0, 1)) ? rama_pkg::KIND_ADD : rama_pkg::KIND_QUERY;
        hi = $urandom_range(0, LEAVES - 2);
        lo = $urandom_range(hi + 1, LEAVES - 1);
      end
      send_word(k, 10'(lo), 10'(hi), 16'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    kind = rama_pkg::KIND_ADD;
    left_index = '0;
    right_index = '0;
    add_value = '0;
    out_stall = 1'b0;
    out_hold = 0;
    fail_count = 0;
    idle_enable = 1'b1;
    sticky_ovf = 1'b0;
    clear_tree();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_extremes();
    test_random(1400);
    // closing stretch with no idling
    idle_enable = 1'b0;
    test_random(300);
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (400) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Run limit
  initial begin
    #60ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
